// ===== rtl/core/murmur3_x64_128_hash_macros.svh =====
// assertion macros shared by the murmur3 x64 128 hash rtl
`ifndef MURMUR3_X64_128_HASH_MACROS_SVH
`define MURMUR3_X64_128_HASH_MACROS_SVH

// same-cycle implication, checked outside reset
`define MM3_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MM3_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/mm3_pkg.sv =====
// types, constants and helper functions for the murmur3 x64 128 hash
package mm3_pkg;

  localparam int LENGTH_BITS = 31;

  localparam logic [4:0] BLOCK_BYTES = 5'd16;
  localparam logic [4:0] WORD_BYTES  = 5'd8;
  localparam logic [4:0] NO_OFFSET   = 5'd0;

  localparam logic [63:0] MIX_C1  = 64'h87c37b91114253d5;
  localparam logic [63:0] MIX_C2  = 64'h4cf5ad432745937f;
  localparam logic [63:0] ADD_ONE = 64'h0000000052dce729;
  localparam logic [63:0] ADD_TWO = 64'h0000000038495ab5;
  localparam logic [63:0] FIN_M1  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FIN_M2  = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [3:0] {
    S_IDLE,
    S_K1A,
    S_K1B,
    S_L1MIX,
    S_K2A,
    S_K2B,
    S_L2MIX,
    S_FIN0,
    S_FIN1,
    S_F1A,
    S_F1B,
    S_F2A,
    S_F2B,
    S_FIN2,
    S_FIN3
  } state_e;

  typedef enum logic [2:0] {
    MS_LL,
    MS_LH,
    MS_HL,
    MS_SUM,
    MS_DONE
  } mul_step_e;

  typedef struct packed {
    logic        run;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] fmix_shift(input logic [63:0] h);
    return h ^ (h >> 33);
  endfunction

  // keeps byte i of the word when base + i lies below the byte count
  function automatic logic [63:0] byte_mask(input logic [4:0] n, input logic [4:0] base);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = ((base + 5'(i)) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/mm3_mul64.sv =====
// 64 by 64 bit low-half multiplier built on one shared 32 by 32 multiplier
`include "murmur3_x64_128_hash_macros.svh"

module mm3_mul64 (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mm3_pkg::mul_req_t req_i,
  output logic             done_o,
  output logic [63:0]      prod_o
);

  mm3_pkg::mul_step_e step_q, step_d;
  logic [31:0] op_a, op_b;
  logic [63:0] pp_d, pp_q;
  logic [63:0] acc_d, acc_q;

  // operand halves for the partial product of this step
  always_comb begin
    case (step_q)
      mm3_pkg::MS_LL: begin
        op_a = req_i.a[31:0];
        op_b = req_i.b[31:0];
      end
      mm3_pkg::MS_LH: begin
        op_a = req_i.a[31:0];
        op_b = req_i.b[63:32];
      end
      mm3_pkg::MS_HL: begin
        op_a = req_i.a[63:32];
        op_b = req_i.b[31:0];
      end
      default: begin
        op_a = req_i.a[31:0];
        op_b = req_i.b[31:0];
      end
    endcase
  end

  assign pp_d = op_a * op_b;

  // cross products only reach the upper half of the low 64 bits
  always_comb begin
    acc_d = acc_q;
    case (step_q)
      mm3_pkg::MS_LH:  acc_d = pp_q;
      mm3_pkg::MS_HL:  acc_d = acc_q + {pp_q[31:0], 32'h0};
      mm3_pkg::MS_SUM: acc_d = acc_q + {pp_q[31:0], 32'h0};
      default:         acc_d = acc_q;
    endcase
  end

  always_comb begin
    if (!req_i.run) begin
      step_d = mm3_pkg::MS_LL;
    end else begin
      case (step_q)
        mm3_pkg::MS_LL:  step_d = mm3_pkg::MS_LH;
        mm3_pkg::MS_LH:  step_d = mm3_pkg::MS_HL;
        mm3_pkg::MS_HL:  step_d = mm3_pkg::MS_SUM;
        mm3_pkg::MS_SUM: step_d = mm3_pkg::MS_DONE;
        default:         step_d = mm3_pkg::MS_LL;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= mm3_pkg::MS_LL;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q  <= pp_d;
    acc_q <= acc_d;
  end

  assign done_o = req_i.run && (step_q == mm3_pkg::MS_DONE);
  assign prod_o = acc_q;

  `MM3_ASSERT_IMPL(a_done_needs_run, clk_i, rst_ni, done_o, req_i.run, "product done without a request")
  `MM3_ASSERT_NEXT(a_idle_restarts, clk_i, rst_ni, !req_i.run, step_q == mm3_pkg::MS_LL, "step counter not rewound when idle")
  `MM3_ASSERT_NEXT(a_step_leaves_ll, clk_i, rst_ni, req_i.run && step_q == mm3_pkg::MS_LL, step_q == mm3_pkg::MS_LH, "step counter stuck")

endmodule

// ===== rtl/core/murmur3_x64_128_hash.sv =====
// a non-final beat keeps the block busy for four 64-bit products
// a final beat shows its result beat once four more products finalise it
// all products run on the one shared 32x32 multiplier behind the sequencer
// a result beat waits in an output register, so the next input beat is taken meanwhile
// async active-low reset clears the sequencer, lanes, byte total, flags and seed to zero
// top level of the murmur3 x64 128 hash: sequencer, lanes and output register
`include "murmur3_x64_128_hash_macros.svh"

module murmur3_x64_128_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_seed_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] low_word_i,
  input  logic [63:0] high_word_i,
  input  logic [4:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_low_o,
  output logic [63:0] hash_high_o,
  output logic        length_overflow_o
);

  localparam int LB = mm3_pkg::LENGTH_BITS;

  mm3_pkg::state_e   state_q, state_d;
  mm3_pkg::mul_req_t mul_req;
  logic              mul_done;
  logic [63:0]       mul_prod;

  logic [31:0]   seed_q, seed_d;
  logic [63:0]   l1_q, l1_d, l2_q, l2_d;
  logic [63:0]   x_q, x_d, w1_q, w1_d;
  logic [LB-1:0] tot_q, tot_d;
  logic          ovf_q, ovf_d;
  logic          inmsg_q, inmsg_d;
  logic          body_q, body_d;
  logic          last_q, last_d;
  logic          out_valid_q, out_valid_d;
  logic [63:0]   hash_low_q, hash_low_d, hash_high_q, hash_high_d;
  logic          ovf_out_q, ovf_out_d;

  logic          in_body;
  logic [4:0]    n_eff;
  logic [LB:0]   tot_sum;
  logic [63:0]   tot_ext;
  logic          out_free;

  assign in_body  = !last_i || (byte_count_i >= mm3_pkg::BLOCK_BYTES);
  assign n_eff    = in_body ? mm3_pkg::BLOCK_BYTES : byte_count_i;
  assign tot_sum  = {1'b0, (inmsg_q ? tot_q : {LB{1'b0}})} + {{(LB-4){1'b0}}, n_eff};
  assign tot_ext  = {{(64-LB){1'b0}}, tot_q};
  assign out_free = !out_valid_q || !out_stall_i;

  // shared multiplier request
  always_comb begin
    mul_req.a   = x_q;
    mul_req.run = 1'b1;
    case (state_q)
      mm3_pkg::S_K1A: mul_req.b = mm3_pkg::MIX_C1;
      mm3_pkg::S_K1B: mul_req.b = mm3_pkg::MIX_C2;
      mm3_pkg::S_K2A: mul_req.b = mm3_pkg::MIX_C2;
      mm3_pkg::S_K2B: mul_req.b = mm3_pkg::MIX_C1;
      mm3_pkg::S_F1A: mul_req.b = mm3_pkg::FIN_M1;
      mm3_pkg::S_F1B: mul_req.b = mm3_pkg::FIN_M2;
      mm3_pkg::S_F2A: mul_req.b = mm3_pkg::FIN_M1;
      mm3_pkg::S_F2B: mul_req.b = mm3_pkg::FIN_M2;
      default: begin
        mul_req.b   = '0;
        mul_req.run = 1'b0;
      end
    endcase
  end

  mm3_mul64 u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mm3_pkg::S_IDLE:  if (in_valid_i) state_d = mm3_pkg::S_K1A;
      mm3_pkg::S_K1A:   if (mul_done) state_d = mm3_pkg::S_K1B;
      mm3_pkg::S_K1B:   if (mul_done) state_d = body_q ? mm3_pkg::S_L1MIX : mm3_pkg::S_K2A;
      mm3_pkg::S_L1MIX: state_d = mm3_pkg::S_K2A;
      mm3_pkg::S_K2A:   if (mul_done) state_d = mm3_pkg::S_K2B;
      mm3_pkg::S_K2B:   if (mul_done) state_d = body_q ? mm3_pkg::S_L2MIX : mm3_pkg::S_FIN0;
      mm3_pkg::S_L2MIX: state_d = last_q ? mm3_pkg::S_FIN0 : mm3_pkg::S_IDLE;
      mm3_pkg::S_FIN0:  state_d = mm3_pkg::S_FIN1;
      mm3_pkg::S_FIN1:  state_d = mm3_pkg::S_F1A;
      mm3_pkg::S_F1A:   if (mul_done) state_d = mm3_pkg::S_F1B;
      mm3_pkg::S_F1B:   if (mul_done) state_d = mm3_pkg::S_F2A;
      mm3_pkg::S_F2A:   if (mul_done) state_d = mm3_pkg::S_F2B;
      mm3_pkg::S_F2B:   if (mul_done) state_d = mm3_pkg::S_FIN2;
      mm3_pkg::S_FIN2:  state_d = mm3_pkg::S_FIN3;
      mm3_pkg::S_FIN3:  if (out_free) state_d = mm3_pkg::S_IDLE;
      default:          state_d = mm3_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    seed_d      = cfg_valid_i ? cfg_seed_i : seed_q;
    l1_d        = l1_q;
    l2_d        = l2_q;
    x_d         = x_q;
    w1_d        = w1_q;
    tot_d       = tot_q;
    ovf_d       = ovf_q;
    inmsg_d     = inmsg_q;
    body_d      = body_q;
    last_d      = last_q;
    hash_low_d  = hash_low_q;
    hash_high_d = hash_high_q;
    ovf_out_d   = ovf_out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      mm3_pkg::S_IDLE: begin
        if (in_valid_i) begin
          // bytes past the count are masked so a zero word scrambles to zero
          x_d     = low_word_i & mm3_pkg::byte_mask(n_eff, mm3_pkg::NO_OFFSET);
          w1_d    = high_word_i & mm3_pkg::byte_mask(n_eff, mm3_pkg::WORD_BYTES);
          body_d  = in_body;
          last_d  = last_i;
          tot_d   = tot_sum[LB-1:0];
          ovf_d   = (inmsg_q && ovf_q) || tot_sum[LB];
          inmsg_d = 1'b1;
          if (!inmsg_q) begin
            l1_d = {32'h0, seed_q};
            l2_d = {32'h0, seed_q};
          end
        end
      end
      mm3_pkg::S_K1A: begin
        if (mul_done) x_d = mm3_pkg::rotl64(mul_prod, 31);
      end
      mm3_pkg::S_K1B: begin
        if (mul_done) begin
          if (body_q) l1_d = mm3_pkg::rotl64(l1_q ^ mul_prod, 27) + l2_q;
          else l1_d = l1_q ^ mul_prod;
          x_d = w1_q;
        end
      end
      mm3_pkg::S_L1MIX: l1_d = l1_q + {l1_q[61:0], 2'b00} + mm3_pkg::ADD_ONE;
      mm3_pkg::S_K2A: begin
        if (mul_done) x_d = mm3_pkg::rotl64(mul_prod, 33);
      end
      mm3_pkg::S_K2B: begin
        if (mul_done) begin
          if (body_q) l2_d = mm3_pkg::rotl64(l2_q ^ mul_prod, 31) + l1_q;
          else l2_d = l2_q ^ mul_prod;
        end
      end
      mm3_pkg::S_L2MIX: l2_d = l2_q + {l2_q[61:0], 2'b00} + mm3_pkg::ADD_TWO;
      mm3_pkg::S_FIN0: begin
        l1_d = (l1_q ^ tot_ext) + (l2_q ^ tot_ext);
        l2_d = l2_q ^ tot_ext;
      end
      mm3_pkg::S_FIN1: begin
        l2_d = l2_q + l1_q;
        x_d  = mm3_pkg::fmix_shift(l1_q);
      end
      mm3_pkg::S_F1A: begin
        if (mul_done) x_d = mm3_pkg::fmix_shift(mul_prod);
      end
      mm3_pkg::S_F1B: begin
        if (mul_done) begin
          l1_d = mm3_pkg::fmix_shift(mul_prod);
          x_d  = mm3_pkg::fmix_shift(l2_q);
        end
      end
      mm3_pkg::S_F2A: begin
        if (mul_done) x_d = mm3_pkg::fmix_shift(mul_prod);
      end
      mm3_pkg::S_F2B: begin
        if (mul_done) l2_d = mm3_pkg::fmix_shift(mul_prod);
      end
      mm3_pkg::S_FIN2: l1_d = l1_q + l2_q;
      mm3_pkg::S_FIN3: begin
        // result beat waits for the output register to drain
        if (out_free) begin
          hash_low_d  = l1_q;
          hash_high_d = l2_q + l1_q;
          ovf_out_d   = ovf_q;
          out_valid_d = 1'b1;
          inmsg_d     = 1'b0;
          tot_d       = '0;
          ovf_d       = 1'b0;
        end
      end
      default: begin
        l1_d = l1_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mm3_pkg::S_IDLE;
      seed_q      <= '0;
      l1_q        <= '0;
      l2_q        <= '0;
      tot_q       <= '0;
      ovf_q       <= 1'b0;
      inmsg_q     <= 1'b0;
      body_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      l1_q        <= l1_d;
      l2_q        <= l2_d;
      tot_q       <= tot_d;
      ovf_q       <= ovf_d;
      inmsg_q     <= inmsg_d;
      body_q      <= body_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    w1_q        <= w1_d;
    hash_low_q  <= hash_low_d;
    hash_high_q <= hash_high_d;
    ovf_out_q   <= ovf_out_d;
  end

  assign cfg_ready_o       = 1'b1;
  assign in_stall_o        = (state_q != mm3_pkg::S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign hash_low_o        = hash_low_q;
  assign hash_high_o       = hash_high_q;
  assign length_overflow_o = ovf_out_q;

  `MM3_ASSERT_IMPL(a_busy_in_message, clk_i, rst_ni, state_q != mm3_pkg::S_IDLE, inmsg_q, "busy outside a message")
  `MM3_ASSERT_NEXT(a_beat_starts_mix, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == mm3_pkg::S_K1A, "accepted beat did not start mixing")
  `MM3_ASSERT_IMPL(a_result_from_final, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == mm3_pkg::S_FIN3, "result beat without finalisation")
  `MM3_ASSERT_NEXT(a_final_clears_total, clk_i, rst_ni, state_q == mm3_pkg::S_FIN3 && out_free, !inmsg_q && tot_q == '0 && !ovf_q, "message state not cleared after result")

endmodule
